@@ sv/bfm_pkg.sv @@
// ----------------------------------------------------------------------------
// bfm_pkg: shared constants and types for the 5x5 box filter
// Image size, widths, line store control struct, divide-by-25 helper.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int IMG_WIDTH  = 64;
  localparam int IMG_HEIGHT = 64;

  localparam int CNT_W  = 6;                    // row / column counter width
  localparam int PIX_W  = 8;
  localparam int LINES  = 4;                    // rows held in the line store
  localparam int WIN    = 5;                    // window edge length

  localparam int LS_AW  = $clog2(IMG_WIDTH);    // one line store word per column
  localparam int LS_DW  = LINES * PIX_W;        // four stacked pixels per word

  localparam int COL_SUM_W = PIX_W + 3;         // 5 * 255 fits in 11 bits
  localparam int WIN_SUM_W = PIX_W + 5;         // 25 * 255 fits in 13 bits
  localparam int MAX_SUM   = WIN * WIN * 255;

  // floor(s / 25) = (s * DIV_MULT) >> DIV_SHIFT for s <= MAX_SUM
  localparam int DIV_SHIFT  = 18;
  localparam int DIV_MULT   = ((2 ** DIV_SHIFT) + 24) / 25;
  localparam int DIV_MULT_W = 14;
  localparam int DIV_PROD_W = WIN_SUM_W + DIV_MULT_W;

  typedef struct packed {
    logic             rd_en;
    logic [LS_AW-1:0] rd_addr;
    logic             wr_en;
    logic [LS_AW-1:0] wr_addr;
  } ls_ctrl_t;

  function automatic logic [PIX_W-1:0] div25(input logic [WIN_SUM_W-1:0] s);
    logic [DIV_PROD_W-1:0] p;
    p = DIV_PROD_W'(s) * DIV_PROD_W'(DIV_MULT);
    return p[DIV_SHIFT+PIX_W-1:DIV_SHIFT];
  endfunction

endpackage

@@ sv/bfm_line_store.sv @@
// ----------------------------------------------------------------------------
// bfm_line_store: four-line pixel store, one word per column
// One registered read and one write per cycle; a same-column write bypasses.
// ----------------------------------------------------------------------------
module bfm_line_store (
  input  logic                     clk_i,
  input  bfm_pkg::ls_ctrl_t        ctrl_i,
  input  logic [bfm_pkg::LS_DW-1:0] wr_data_i,
  output logic [bfm_pkg::LS_DW-1:0] rd_data_o
);

  logic [bfm_pkg::LS_DW-1:0] mem_q [bfm_pkg::IMG_WIDTH];
  logic [bfm_pkg::LS_DW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr] <= wr_data_i;
    end
  end

  // read of the column being written this cycle returns the new word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      if (ctrl_i.wr_en && (ctrl_i.wr_addr == ctrl_i.rd_addr)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem_q[ctrl_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

@@ sv/bfm_col_cell.sv @@
// ----------------------------------------------------------------------------
// bfm_col_cell: one window column, held as the sum of its five pixels
// Takes its right neighbor's sum on every shift.
// ----------------------------------------------------------------------------
module bfm_col_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic [bfm_pkg::COL_SUM_W-1:0] sum_i,
  output logic [bfm_pkg::COL_SUM_W-1:0] sum_o
);

  logic [bfm_pkg::COL_SUM_W-1:0] sum_q;
  logic [bfm_pkg::COL_SUM_W-1:0] sum_d;

  always_comb begin
    sum_d = shift_i ? sum_i : sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ sv/box_filter_5x5_mean.sv @@
// ----------------------------------------------------------------------------
// box_filter_5x5_mean: streaming 5x5 mean filter
// Raster pixels in, truncated 5x5 window means for interior pixels out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: pixel_i / frame_start_i with in_valid_i, in_stall_o. One
//   transaction per pixel in raster order; frame_start_i restarts the row and
//   column counters at this pixel. Counters also wrap after the last pixel.
//   Output channel: center_row_o / center_col_o / mean_value_o / frame_done_o
//   with out_valid_o, out_stall_i. One transaction per pixel whose 5x5 window
//   lies inside the image (row >= 4 and col >= 4); other pixels give none.
//   The two-pixel border is never sent.
//   Pipeline: a pixel passes stage 1 (line store read), stage 2 (window sum)
//   and stage 3 (output register, divide by 25) in that order.
//   Throughput: one pixel per clock while in_stall_o is low, set by the line
//   store doing one column read and one column write per accepted pixel.
//   Receiver stall: the result holds in the output register; the pipeline
//   behind it keeps taking pixels until a result is stuck in the sum stage and
//   stage 1 is full, then in_stall_o rises. Non-emitting pixels never block.
//   Reset: counters, window column sums and valid bits clear. The line store
//   is not cleared; its stale words only feed windows that are never emitted.
// ----------------------------------------------------------------------------
module box_filter_5x5_mean (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bfm_pkg::PIX_W-1:0]       pixel_i,
  input  logic                            frame_start_i,
  // mean output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bfm_pkg::CNT_W-1:0]       center_row_o,
  output logic [bfm_pkg::CNT_W-1:0]       center_col_o,
  output logic [bfm_pkg::PIX_W-1:0]       mean_value_o,
  output logic                            frame_done_o
);

  localparam int CW = bfm_pkg::CNT_W;
  localparam int PW = bfm_pkg::PIX_W;
  localparam int CSW = bfm_pkg::COL_SUM_W;
  localparam int WSW = bfm_pkg::WIN_SUM_W;

  // --------------------------------------------------------------------------
  // Handshake / stage enables
  // --------------------------------------------------------------------------
  logic v1_q, v1_d;
  logic v2_q, v2_d;
  logic out_valid_q, out_valid_d;
  logic emit2_q;
  logic out_free, en2, en1, adv1, acc_in, load_out;

  assign out_free = !out_valid_q || !out_stall_i;
  // sum stage drains when its transaction emits nothing or the output is free
  assign en2      = !v2_q || !emit2_q || out_free;
  assign adv1     = v1_q && en2;
  assign en1      = !v1_q || en2;
  assign in_stall_o = !en1;
  assign acc_in   = in_valid_i && en1;
  assign load_out = v2_q && emit2_q && out_free;

  // --------------------------------------------------------------------------
  // Raster counters (position of the next pixel)
  // --------------------------------------------------------------------------
  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic [CW-1:0] row_cur, col_cur;

  always_comb begin
    row_cur = frame_start_i ? '0 : row_q;
    col_cur = frame_start_i ? '0 : col_q;
    row_d = row_q;
    col_d = col_q;
    if (acc_in) begin
      if (col_cur >= CW'(bfm_pkg::IMG_WIDTH - 1)) begin
        col_d = '0;
        row_d = (row_cur >= CW'(bfm_pkg::IMG_HEIGHT - 1)) ? '0 : row_cur + CW'(1);
      end else begin
        col_d = col_cur + CW'(1);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: pixel and tags wait for the line store read
  // --------------------------------------------------------------------------
  logic [PW-1:0]             px1_q;
  logic [bfm_pkg::LS_AW-1:0] col1_q;
  logic                      emit1_q, last1_q;
  logic [CW-1:0]             crow1_q, ccol1_q;

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      px1_q   <= pixel_i;
      col1_q  <= col_cur[bfm_pkg::LS_AW-1:0];
      emit1_q <= (row_cur >= CW'(4)) && (col_cur >= CW'(4));
      last1_q <= (row_cur == CW'(bfm_pkg::IMG_HEIGHT - 1)) &&
                 (col_cur == CW'(bfm_pkg::IMG_WIDTH - 1));
      crow1_q <= row_cur - CW'(2);
      ccol1_q <= col_cur - CW'(2);
    end
  end

  // line store: read at accept, write the shifted column when stage 1 leaves
  bfm_pkg::ls_ctrl_t           ls_ctrl;
  logic [bfm_pkg::LS_DW-1:0]   ls_rd, ls_wr;

  always_comb begin
    ls_ctrl.rd_en   = acc_in;
    ls_ctrl.rd_addr = col_cur[bfm_pkg::LS_AW-1:0];
    ls_ctrl.wr_en   = adv1;
    ls_ctrl.wr_addr = col1_q;
  end

  // oldest row drops out, the new pixel becomes the newest row
  assign ls_wr = {px1_q, ls_rd[bfm_pkg::LS_DW-1:PW]};

  bfm_line_store u_line_store (
    .clk_i     (clk_i),
    .ctrl_i    (ls_ctrl),
    .wr_data_i (ls_wr),
    .rd_data_o (ls_rd)
  );

  // new window column sum: four stored rows plus the incoming pixel
  logic [CSW-1:0] new_col_sum;

  always_comb begin
    new_col_sum = CSW'(px1_q);
    for (int i = 0; i < bfm_pkg::LINES; i++) begin
      new_col_sum = new_col_sum + CSW'(ls_rd[i*PW +: PW]);
    end
  end

  // --------------------------------------------------------------------------
  // Window: chain of column cells, leftmost at index 0
  // --------------------------------------------------------------------------
  logic [CSW-1:0] cell_sum [bfm_pkg::WIN];

  for (genvar g = 0; g < bfm_pkg::WIN; g++) begin : g_cell
    logic [CSW-1:0] cell_in;
    if (g == bfm_pkg::WIN - 1) begin : g_head
      assign cell_in = new_col_sum;
    end else begin : g_body
      assign cell_in = cell_sum[g+1];
    end
    bfm_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (adv1),
      .sum_i   (cell_in),
      .sum_o   (cell_sum[g])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 2: window sum, rebuilt from the shifted cells on every move so a
  // stale column drops out completely once it leaves the window
  // --------------------------------------------------------------------------
  logic [WSW-1:0] sum_q, sum_d;
  logic           last2_q;
  logic [CW-1:0]  crow2_q, ccol2_q;

  always_comb begin
    v1_d  = en1 ? acc_in : v1_q;
    v2_d  = en2 ? adv1 : v2_q;
    sum_d = sum_q;
    if (adv1) begin
      sum_d = (WSW'(cell_sum[1]) + WSW'(cell_sum[2])) +
              (WSW'(cell_sum[3]) + WSW'(cell_sum[4])) + WSW'(new_col_sum);
    end
    out_valid_d = load_out ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      emit2_q <= emit1_q;
      last2_q <= last1_q;
      crow2_q <= crow1_q;
      ccol2_q <= ccol1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: output register, divide by 25 via reciprocal multiply
  // --------------------------------------------------------------------------
  logic [CW-1:0] crow_q, ccol_q;
  logic [PW-1:0] mean_q;
  logic          done_q;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      crow_q <= crow2_q;
      ccol_q <= ccol2_q;
      mean_q <= bfm_pkg::div25(sum_q);
      done_q <= last2_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign center_row_o = crow_q;
  assign center_col_o = ccol_q;
  assign mean_value_o = mean_q;
  assign frame_done_o = done_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sum_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && emit2_q) |-> (sum_q <= WSW'(bfm_pkg::MAX_SUM)))
    else $error("window sum out of range");

  a_interior : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (crow_q >= CW'(2)) && (ccol_q >= CW'(2)))
    else $error("border position emitted");

  a_done_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |->
      (crow_q == CW'(bfm_pkg::IMG_HEIGHT - 3)) && (ccol_q == CW'(bfm_pkg::IMG_WIDTH - 3)))
    else $error("frame_done on wrong position");

  a_no_shift_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && emit2_q && out_valid_q && out_stall_i) |=> $stable(sum_q))
    else $error("window moved while sum stage blocked");

endmodule

@@ dv/tb_box_filter_5x5_mean.sv @@
// ----------------------------------------------------------------------------
// tb_box_filter_5x5_mean: self-checking bench for the streaming 5x5 mean filter
// Streams raster pixels into the block, mirrors the line store and window in
// a behavioral predictor, and checks every emitted mean, centre position and
// frame_done flag in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_box_filter_5x5_mean;
  import bfm_pkg::*;

  // No transaction in or out for this many cycles means the block is hung.
  // A correct run never goes quiet for longer than one sender gap plus one
  // receiver stall plus the pipeline depth.
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_CYC   = 8;     // settle time after the last mean is received
  localparam int FRAME_PIXELS = IMG_WIDTH * IMG_HEIGHT;

  // Content pattern for a generated frame.
  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_MAX,
    FILL_EXTREME                       // each pixel is 0 or 255
  } px_fill_e;

  // One pending input transaction. hold_for_drain makes the sender wait
  // until every outstanding mean has been received before presenting it.
  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             frame_start;
    logic             hold_for_drain;
  } px_item_t;

  typedef struct {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic [PIX_W-1:0] mean;
    logic             done;
  } mean_result_t;

  // DUT ports; every input starts at a known value.
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [PIX_W-1:0] pixel_i       = '0;
  logic             frame_start_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [CNT_W-1:0] center_row_o;
  logic [CNT_W-1:0] center_col_o;
  logic [PIX_W-1:0] mean_value_o;
  logic             frame_done_o;

  px_item_t     px_pending[$];         // stimulus not yet presented
  mean_result_t means_due[$];          // predicted means, oldest first

  // Predictor state: the four buffered rows per column (index 0 oldest),
  // the 5x5 window (column 4 newest), and the position of the next pixel.
  logic [PIX_W-1:0] line_mem [LINES][IMG_WIDTH];
  logic [PIX_W-1:0] win_px   [WIN][WIN];
  logic [CNT_W-1:0] next_row = '0;
  logic [CNT_W-1:0] next_col = '0;

  // Handshake results of the last rising edge, read by the falling-edge drivers.
  logic px_taken  = 1'b0;
  logic res_taken = 1'b0;

  int fail_cnt     = 0;
  int quiet_cycles = 0;
  int gap_left     = 0;                // sender idle cycles before next pixel
  int stall_left   = 0;                // receiver stall cycles on current result
  bit drv_burst    = 1'b0;             // burst mode: sender never idles
  bit rcv_burst    = 1'b0;             // burst mode: receiver never stalls

  box_filter_5x5_mean dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .center_row_o  (center_row_o),
    .center_col_o  (center_col_o),
    .mean_value_o  (mean_value_o),
    .frame_done_o  (frame_done_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor: takes one accepted pixel, updates the mirrored line store and
  // window, and queues a mean when the window is fully inside the frame.
  // --------------------------------------------------------------------------
  task automatic box_mean_step(input logic [PIX_W-1:0] pix, input logic fs);
    int           sum;
    mean_result_t res;
    // frame_start restarts the position before this pixel is placed
    if (fs) begin
      next_row = '0;
      next_col = '0;
    end
    // window slides left; the new column is the buffered rows plus this pixel
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) win_px[r][c] = win_px[r][c+1];
    end
    for (int r = 0; r < LINES; r++) win_px[r][WIN-1] = line_mem[r][next_col];
    win_px[WIN-1][WIN-1] = pix;
    // this column of the line store moves up one row
    for (int r = 0; r < LINES - 1; r++) line_mem[r][next_col] = line_mem[r+1][next_col];
    line_mem[LINES-1][next_col] = pix;

    if (next_row >= CNT_W'(WIN - 1) && next_col >= CNT_W'(WIN - 1)) begin
      sum = 0;
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) sum += win_px[r][c];
      end
      res.row  = next_row - CNT_W'(2);
      res.col  = next_col - CNT_W'(2);
      res.mean = PIX_W'(sum / (WIN * WIN));
      res.done = (next_row == CNT_W'(IMG_HEIGHT - 1)) &&
                 (next_col == CNT_W'(IMG_WIDTH - 1));
      means_due.push_back(res);
    end

    // raster advance; wraps to the top-left corner after the last pixel
    if (next_col == CNT_W'(IMG_WIDTH - 1)) begin
      next_col = '0;
      next_row = (next_row == CNT_W'(IMG_HEIGHT - 1)) ? '0 : next_row + CNT_W'(1);
    end else begin
      next_col = next_col + CNT_W'(1);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                             input logic hold);
    px_item_t it;
    it.pix            = pix;
    it.frame_start    = fs;
    it.hold_for_drain = hold;
    px_pending.push_back(it);
  endtask

  function automatic logic [PIX_W-1:0] fill_pixel(input px_fill_e mode);
    case (mode)
      FILL_ZERO:    return '0;
      FILL_MAX:     return '1;
      FILL_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      default:      return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // A frame opens with frame_start; restart_at > 0 plants a second
  // frame_start part way through (a broken frame). Pixels past the frame
  // size simply wrap into the next frame.
  task automatic queue_frame(input int n_px, input px_fill_e mode,
                             input logic hold, input int restart_at);
    for (int i = 0; i < n_px; i++) begin
      queue_pixel(fill_pixel(mode), (i == 0) || (i == restart_at), (i == 0) && hold);
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: presents the next pending pixel at the falling edge after
  // the random idle gap; a stalled pixel stays put until it is taken.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    px_item_t nxt;
    logic     nv;
    if (rst_ni) begin
      nv = in_valid_i;
      if (in_valid_i && px_taken) begin
        nv       = 1'b0;
        gap_left = drv_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 49) == 0) drv_burst = !drv_burst;
      end
      if (!nv) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (px_pending.size() != 0 &&
                     (!px_pending[0].hold_for_drain || means_due.size() == 0)) begin
          nxt = px_pending.pop_front();
          nv  = 1'b1;
          pixel_i       <= nxt.pix;
          frame_start_i <= nxt.frame_start;
        end
      end
      in_valid_i <= nv;
    end
  end

  // --------------------------------------------------------------------------
  // Output stall driver: each received mean draws a stall length, spent only
  // on cycles where a result is actually waiting.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic ns;
    if (rst_ni) begin
      if (res_taken) begin
        stall_left = rcv_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 49) == 0) rcv_burst = !rcv_burst;
      end
      ns = (stall_left != 0);
      if (stall_left != 0 && out_valid_o) stall_left--;
      out_stall_i <= ns;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and scoreboard at the rising edge. The result check runs before
  // the prediction of a pixel taken on the same edge; stage 1 and the sum stage
  // lie between that pixel and the output register, so it cannot own this result.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    mean_result_t want;
    if (rst_ni) begin
      px_taken  = in_valid_i && !in_stall_o;
      res_taken = out_valid_o && !out_stall_i;
      if (res_taken) begin
        if (means_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual row %0d col %0d mean %0d",
                   $time, center_row_o, center_col_o, mean_value_o);
          fail_cnt++;
        end else begin
          want = means_due.pop_front();
          check_field("center_row", want.row, center_row_o);
          check_field("center_col", want.col, center_col_o);
          check_field("mean_value", want.mean, mean_value_o);
          check_field("frame_done", want.done, frame_done_o);
        end
      end
      if (px_taken) box_mean_step(pixel_i, frame_start_i);

      if (px_taken || res_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build the stimulus, reset, then wait for everything to drain.
  // --------------------------------------------------------------------------
  initial begin
    for (int r = 0; r < LINES; r++) begin
      for (int c = 0; c < IMG_WIDTH; c++) line_mem[r][c] = '0;
    end
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN; c++) win_px[r][c] = '0;
    end

    // Directed: pixel extremes and alternating bit patterns, back-to-back
    // frame_start pulses and restarts a few pixels in. Too short for any
    // window to fill, so no mean may appear.
    queue_pixel(8'hFF, 1'b1, 1'b0);
    queue_pixel(8'h00, 1'b1, 1'b0);
    queue_pixel(8'hFF, 1'b0, 1'b0);
    queue_pixel(8'hAA, 1'b0, 1'b0);
    queue_pixel(8'h55, 1'b0, 1'b0);
    queue_pixel(8'h01, 1'b0, 1'b0);
    queue_pixel(8'h80, 1'b1, 1'b0);
    queue_pixel(8'h7F, 1'b0, 1'b0);
    queue_pixel(8'hFE, 1'b0, 1'b0);
    queue_pixel(8'h00, 1'b0, 1'b0);
    queue_pixel(8'hFF, 1'b1, 1'b0);
    queue_pixel(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++) queue_pixel(i[0] ? 8'hFF : 8'h00, 1'b0, 1'b0);

    // A frame that runs past its fifth row: the first interior means come
    // out, across a row change in the middle of the results.
    queue_frame(4 * IMG_WIDTH + 100, FILL_RANDOM, 1'b1, 0);

    // The same frame goes on without frame_start at full scale; the sender
    // first waits until every mean so far has been received.
    for (int i = 0; i < 70; i++) queue_pixel(fill_pixel(FILL_MAX), 1'b0, i == 0);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (px_pending.size() == 0 && !in_valid_i);
    wait (means_due.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/bfm_pkg.sv
sv/bfm_line_store.sv
sv/bfm_col_cell.sv
sv/box_filter_5x5_mean.sv
dv/tb_box_filter_5x5_mean.sv
